FILE: sv/qrd_pkg.sv
package qrd_pkg;

    // Configuration port
    localparam int CFG_AW = 4;
    localparam logic [1:0] REG_ALPHA_MODE    = 2'd0;
    localparam logic [1:0] REG_PALETTE_COUNT = 2'd1;
    localparam logic [1:0] REG_VISIBLE_START = 2'd2;
    localparam logic [1:0] REG_VISIBLE_END   = 2'd3;

    // Palette
    localparam int PALETTE_DEPTH_DEF = 64;
    localparam int PAL_WORD_W        = 24;

    // Input commands
    localparam logic [1:0] CMD_CODE          = 2'd0;
    localparam logic [1:0] CMD_PALETTE_WRITE = 2'd1;
    localparam logic [1:0] CMD_ROW_START     = 2'd2;

    // Result status
    localparam logic STATUS_PIXEL = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    // Multi-byte opcode progress
    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_ALPHA = 3'd1;
    localparam logic [2:0] OP_HIGH  = 3'd2;
    localparam logic [2:0] OP_LOW   = 3'd3;
    localparam logic [2:0] OP_LUMA  = 3'd4;

    // Opcode bytes
    localparam logic [7:0] OPC_RAW_ALPHA = 8'hFF;
    localparam logic [7:0] OPC_RAW       = 8'hFE;
    localparam logic [1:0] TAG_INDEX     = 2'b00;
    localparam logic [1:0] TAG_DIFF      = 2'b01;
    localparam logic [1:0] TAG_LUMA      = 2'b10;

    localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

endpackage

FILE: sv/qoi_rgb565_row_decoder.sv
// Row decoder for a QOI-style RGB565 code stream (plain RGB565 or ARGB8565 with
// an alpha byte). Items on the cmd channel are a code byte, a palette entry write
// or a row start; results on the pix channel are pixels of the visible window
// [visible_start, visible_end), the last one flagged with row_last, or a single
// error beat when a palette index reaches palette_count (the row then halts
// until the next row start). Row starts, palette writes, ignored bytes and the
// leading bytes of multi-byte opcodes do not raise cmd_stall. A byte that yields
// pixels is accepted first, then the run sequencer steps through every pixel of
// the run (pixels left of the window included, up to 62 for a run byte); a
// palette index first passes through the registered palette RAM read. cmd_stall
// stays high while the sequencer works and while it waits for the pix side to
// take a beat. The palette RAM has no reset and needs no clearing pass: entries
// must be written before an index uses them. Configuration (APB, byte
// addresses 0/4/8/12: alpha_mode, palette_count, visible_start, visible_end)
// is for the user to write only while the block is idle; the block does not enforce it.
module qoi_rgb565_row_decoder #(
    parameter int PALETTE_DEPTH = qrd_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,

    // APB configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [qrd_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,

    // Command channel
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic [1:0]                command,
    input  logic [7:0]                code_byte,
    input  logic [5:0]                palette_slot,
    input  logic [23:0]               palette_word,

    // Pixel channel
    output logic                      pix_valid,
    input  logic                      pix_stall,
    output logic                      status,
    output logic [15:0]               column,
    output logic [15:0]               colour,
    output logic [7:0]                alpha,
    output logic                      row_last
);

    import qrd_pkg::*;

    localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam logic [7:0] DEPTH_LIMIT = 8'(PALETTE_DEPTH);

    // Sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAL  = 2'd1;  // palette RAM read in flight
    localparam logic [1:0] ST_EMIT = 2'd2;  // run loop, one pixel per step
    localparam logic [1:0] ST_ERR  = 2'd3;  // error beat waiting for the slot

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        alpha_mode_reg;
    logic [6:0]  palette_count_reg;
    logic [15:0] visible_start_reg;
    logic [15:0] visible_end_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_mode_reg    <= 1'b0;
            palette_count_reg <= '0;
            visible_start_reg <= '0;
            visible_end_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_ALPHA_MODE:    alpha_mode_reg    <= pwdata[0];
                REG_PALETTE_COUNT: palette_count_reg <= pwdata[6:0];
                REG_VISIBLE_START: visible_start_reg <= pwdata[15:0];
                REG_VISIBLE_END:   visible_end_reg   <= pwdata[15:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ALPHA_MODE:    prdata = {31'd0, alpha_mode_reg};
            REG_PALETTE_COUNT: prdata = {25'd0, palette_count_reg};
            REG_VISIBLE_START: prdata = {16'd0, visible_start_reg};
            REG_VISIBLE_END:   prdata = {16'd0, visible_end_reg};
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Palette RAM (write on palette command, read on index opcode)
    // ------------------------------------------------------------------
    logic                  ram_we;
    logic                  ram_re;
    logic [PAL_WORD_W-1:0] ram_rdata;

    qrd_ram #(
        .WIDTH (PAL_WORD_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (palette_slot[PAL_AW-1:0]),
        .wdata (palette_word),
        .re    (ram_re),
        .raddr (code_byte[PAL_AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Decoder state
    // ------------------------------------------------------------------
    logic [1:0]  state_reg,      state_next;
    logic [4:0]  red_reg,        red_next;
    logic [5:0]  green_reg,      green_next;
    logic [4:0]  blue_reg,       blue_next;
    logic [7:0]  alpha_lvl_reg,  alpha_lvl_next;
    logic [15:0] col_reg,        col_next;
    logic [2:0]  pending_reg,    pending_next;
    logic [7:0]  held_reg,       held_next;
    logic        halted_reg,     halted_next;
    logic [5:0]  run_left_reg,   run_left_next;   // pixels still to go after this one

    // Output register
    logic        pix_valid_reg,  pix_valid_next;
    logic        status_reg,     status_next;
    logic [15:0] column_reg,     column_next;
    logic [15:0] colour_reg,     colour_next;
    logic [7:0]  alpha_reg,      alpha_next;
    logic        row_last_reg,   row_last_next;

    logic        accept;
    logic        slot_free;
    logic        load_out;
    logic [16:0] col_inc;
    logic        in_window;
    logic        past_end;
    logic [5:0]  luma_g;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign slot_free = !pix_valid_reg || !pix_stall;

    // Shared column step: the edge test and row_last hang off it; the window test uses the current column
    assign col_inc   = {1'b0, col_reg} + 17'd1;
    assign in_window = (col_reg >= visible_start_reg) && (col_reg < visible_end_reg);
    assign past_end  = (col_inc >= {1'b0, visible_end_reg});
    assign luma_g    = held_reg[5:0];

    always_comb
    begin
        state_next     = state_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        alpha_lvl_next = alpha_lvl_reg;
        col_next       = col_reg;
        pending_next   = pending_reg;
        held_next      = held_reg;
        halted_next    = halted_reg;
        run_left_next  = run_left_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        load_out       = 1'b0;
        status_next    = status_reg;
        column_next    = column_reg;
        colour_next    = colour_reg;
        alpha_next     = alpha_reg;
        row_last_next  = row_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_PALETTE_WRITE:
                        begin
                            if ({2'b00, palette_slot} < DEPTH_LIMIT)
                            begin
                                ram_we = 1'b1;
                            end
                        end
                        CMD_ROW_START:
                        begin
                            red_next       = '0;
                            green_next     = '0;
                            blue_next      = '0;
                            alpha_lvl_next = ALPHA_OPAQUE;
                            col_next       = '0;
                            pending_next   = OP_NONE;
                            held_next      = '0;
                            halted_next    = 1'b0;
                        end
                        CMD_CODE:
                        begin
                            if (halted_reg || (col_reg >= visible_end_reg))
                            begin
                                halted_next = 1'b1;
                            end
                            else
                            begin
                                case (pending_reg)
                                    OP_ALPHA:
                                    begin
                                        alpha_lvl_next = code_byte;
                                        pending_next   = OP_HIGH;
                                    end
                                    OP_HIGH:
                                    begin
                                        held_next    = code_byte;
                                        pending_next = OP_LOW;
                                    end
                                    OP_LOW:
                                    begin
                                        red_next      = held_reg[7:3];
                                        green_next    = {held_reg[2:0], code_byte[7:5]};
                                        blue_next     = code_byte[4:0];
                                        pending_next  = OP_NONE;
                                        held_next     = '0;
                                        run_left_next = '0;
                                        state_next    = ST_EMIT;
                                    end
                                    OP_LUMA:
                                    begin
                                        // dg = g-32, dr/db biased by 8 relative to dg
                                        red_next      = red_reg + luma_g[4:0]
                                                      + {1'b0, code_byte[7:4]} + 5'd24;
                                        green_next    = green_reg + luma_g + 6'd32;
                                        blue_next     = blue_reg + luma_g[4:0]
                                                      + {1'b0, code_byte[3:0]} + 5'd24;
                                        pending_next  = OP_NONE;
                                        held_next     = '0;
                                        run_left_next = '0;
                                        state_next    = ST_EMIT;
                                    end
                                    default:
                                    begin
                                        pending_next = OP_NONE;
                                        if (code_byte == OPC_RAW_ALPHA)
                                        begin
                                            pending_next = alpha_mode_reg ? OP_ALPHA : OP_HIGH;
                                        end
                                        else if (code_byte == OPC_RAW)
                                        begin
                                            pending_next = OP_HIGH;
                                        end
                                        else if (code_byte[7:6] == TAG_DIFF)
                                        begin
                                            // 2-bit deltas, bias 2
                                            red_next      = red_reg + {3'd0, code_byte[5:4]} - 5'd2;
                                            green_next    = green_reg + {4'd0, code_byte[3:2]} - 6'd2;
                                            blue_next     = blue_reg + {3'd0, code_byte[1:0]} - 5'd2;
                                            run_left_next = '0;
                                            state_next    = ST_EMIT;
                                        end
                                        else if (code_byte[7:6] == TAG_LUMA)
                                        begin
                                            held_next    = code_byte;
                                            pending_next = OP_LUMA;
                                        end
                                        else if (code_byte[7:6] == TAG_INDEX)
                                        begin
                                            if ((code_byte >= {1'b0, palette_count_reg}) ||
                                                (code_byte >= DEPTH_LIMIT))
                                            begin
                                                state_next = ST_ERR;
                                            end
                                            else
                                            begin
                                                ram_re     = 1'b1;
                                                state_next = ST_PAL;
                                            end
                                        end
                                        else
                                        begin
                                            // run of (byte & 0x3F) + 1 pixels
                                            run_left_next = code_byte[5:0];
                                            state_next    = ST_EMIT;
                                        end
                                    end
                                endcase
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PAL:
            begin
                red_next   = ram_rdata[15:11];
                green_next = ram_rdata[10:5];
                blue_next  = ram_rdata[4:0];
                if (alpha_mode_reg)
                begin
                    alpha_lvl_next = ram_rdata[23:16];
                end
                run_left_next = '0;
                state_next    = ST_EMIT;
            end

            ST_EMIT:
            begin
                // off-window pixels step without needing the output slot
                if (!in_window || slot_free)
                begin
                    if (in_window)
                    begin
                        load_out      = 1'b1;
                        status_next   = STATUS_PIXEL;
                        column_next   = col_reg;
                        colour_next   = {red_reg, green_reg, blue_reg};
                        alpha_next    = alpha_mode_reg ? alpha_lvl_reg : ALPHA_OPAQUE;
                        row_last_next = (col_inc == {1'b0, visible_end_reg});
                    end
                    col_next = col_inc[15:0];
                    if (past_end)
                    begin
                        halted_next = 1'b1;
                    end
                    if ((run_left_reg == '0) || past_end)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        run_left_next = run_left_reg - 6'd1;
                    end
                end
            end

            ST_ERR:
            begin
                if (slot_free)
                begin
                    load_out      = 1'b1;
                    status_next   = STATUS_ERROR;
                    column_next   = col_reg;
                    colour_next   = '0;
                    alpha_next    = '0;
                    row_last_next = 1'b0;
                    halted_next   = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load_out)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_valid_reg && !pix_stall)
        begin
            pix_valid_next = 1'b0;
        end
        else
        begin
            pix_valid_next = pix_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            alpha_lvl_reg <= ALPHA_OPAQUE;
            col_reg       <= '0;
            pending_reg   <= OP_NONE;
            held_reg      <= '0;
            halted_reg    <= 1'b1;
            run_left_reg  <= '0;
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            alpha_lvl_reg <= alpha_lvl_next;
            col_reg       <= col_next;
            pending_reg   <= pending_next;
            held_reg      <= held_next;
            halted_reg    <= halted_next;
            run_left_reg  <= run_left_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        column_reg   <= column_next;
        colour_reg   <= colour_next;
        alpha_reg    <= alpha_next;
        row_last_reg <= row_last_next;
    end

    assign pix_valid = pix_valid_reg;
    assign status    = status_reg;
    assign column    = column_reg;
    assign colour    = colour_reg;
    assign alpha     = alpha_reg;
    assign row_last  = row_last_reg;

endmodule

FILE: sv/qrd_ram.sv
module qrd_ram #(
    parameter int WIDTH = qrd_pkg::PAL_WORD_W,
    parameter int DEPTH = qrd_pkg::PALETTE_DEPTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/qrd_checker.sv
module qrd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_valid,
    input logic        cmd_stall,
    input logic [1:0]  command,
    input logic        pix_valid,
    input logic        pix_stall,
    input logic        status,
    input logic [15:0] column,
    input logic [15:0] colour,
    input logic [7:0]  alpha,
    input logic        row_last
);

    import qrd_pkg::*;

    // Stalled pixel beat holds
    a_pix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && pix_stall |=> pix_valid && $stable(status) && $stable(column)
            && $stable(colour) && $stable(alpha) && $stable(row_last))
        else $error("pixel beat changed while stalled");

    // Error beat carries a blank pixel
    a_err_blank: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && (status == STATUS_ERROR) |-> (colour == '0) && (alpha == '0) && !row_last)
        else $error("error beat with pixel data");

    // Palette writes and row starts do not raise cmd_stall
    a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall
            && ((command == CMD_PALETTE_WRITE) || (command == CMD_ROW_START))
        |=> !cmd_stall)
        else $error("control command held the input");

    // A new beat is only produced while the sequencer holds the input
    a_pix_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_valid) |-> $past(cmd_stall))
        else $error("beat appeared outside the run sequencer");

endmodule

bind qoi_rgb565_row_decoder qrd_checker u_qrd_checker (.*);

FILE: verif/tb_qoi_rgb565_row_decoder.sv
module tb_qoi_rgb565_row_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import qrd_pkg::*;

    typedef struct packed {
        logic        status;
        logic [15:0] column;
        logic [15:0] colour;
        logic [7:0]  alpha;
        logic        row_last;
    } pixel_beat_t;

    // Decoder state mirror plus the queue of pixel beats it still owes.
    class row_pixel_model;
        logic [23:0] palette [64];
        logic [4:0]  red;
        logic [5:0]  green;
        logic [4:0]  blue;
        logic [7:0]  alpha_lvl;
        logic [15:0] col_count;
        logic [2:0]  pending;
        logic [7:0]  held;
        bit          halted;
        bit          alpha_mode;
        logic [6:0]  palette_limit;
        logic [15:0] vis_start;
        logic [15:0] vis_end;
        pixel_beat_t owed_pixels [$];
        int          mismatches;
        int          beats_checked;
        int          error_beats;

        function new();
            foreach (palette[i])
                palette[i] = '0;
            alpha_mode    = 0;
            palette_limit = '0;
            vis_start     = '0;
            vis_end       = '0;
            start_row();
            halted = 1;
            mismatches    = 0;
            beats_checked = 0;
            error_beats   = 0;
        endfunction

        function void start_row();
            red       = '0;
            green     = '0;
            blue      = '0;
            alpha_lvl = ALPHA_OPAQUE;
            col_count = '0;
            pending   = OP_NONE;
            held      = '0;
            halted    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_ALPHA_MODE:    alpha_mode    = value[0];
                REG_PALETTE_COUNT: palette_limit = value[6:0];
                REG_VISIBLE_START: vis_start     = value[15:0];
                REG_VISIBLE_END:   vis_end       = value[15:0];
                default: ;
            endcase
        endfunction

        function int outstanding();
            return owed_pixels.size();
        endfunction

        // True when this item would be decoded as a palette index lookup.
        function bit reads_palette(logic [1:0] cmd, logic [7:0] b);
            return cmd == CMD_CODE && !halted && col_count < vis_end &&
                   pending == OP_NONE && b[7:6] == TAG_INDEX && b < palette_limit;
        endfunction

        function void load_rgb(logic [15:0] word);
            red   = word[15:11];
            green = word[10:5];
            blue  = word[4:0];
        endfunction

        function void emit();
            pixel_beat_t px;
            if (col_count >= vis_start && col_count < vis_end) begin
                px.status   = STATUS_PIXEL;
                px.column   = col_count;
                px.colour   = {red, green, blue};
                px.alpha    = alpha_mode ? alpha_lvl : ALPHA_OPAQUE;
                px.row_last = (int'(col_count) + 1 == int'(vis_end));
                owed_pixels.push_back(px);
            end
            col_count = col_count + 16'd1;
            if (col_count >= vis_end)
                halted = 1;
        endfunction

        function void decode_byte(logic [7:0] b);
            pixel_beat_t px;
            int run_len;
            if (halted || col_count >= vis_end) begin
                halted = 1;
                return;
            end
            case (pending)
                OP_ALPHA: begin
                    alpha_lvl = b;
                    pending = OP_HIGH;
                    return;
                end
                OP_HIGH: begin
                    held = b;
                    pending = OP_LOW;
                    return;
                end
                OP_LOW: begin
                    load_rgb({held, b});
                    pending = OP_NONE;
                    held = '0;
                    emit();
                    return;
                end
                OP_LUMA: begin
                    // green bias 32, red/blue bias 32+8
                    red   = 5'((int'(red) + held[5:0] + b[7:4] + 216) & 'h1F);
                    green = 6'((int'(green) + held[5:0] + 32) & 'h3F);
                    blue  = 5'((int'(blue) + held[5:0] + b[3:0] + 216) & 'h1F);
                    pending = OP_NONE;
                    held = '0;
                    emit();
                    return;
                end
                default: pending = OP_NONE;
            endcase

            if (b == OPC_RAW_ALPHA) begin
                pending = alpha_mode ? OP_ALPHA : OP_HIGH;
            end else if (b == OPC_RAW) begin
                pending = OP_HIGH;
            end else if (b[7:6] == TAG_DIFF) begin
                red   = 5'((int'(red) + b[5:4] + 30) & 'h1F);
                green = 6'((int'(green) + b[3:2] + 62) & 'h3F);
                blue  = 5'((int'(blue) + b[1:0] + 30) & 'h1F);
                emit();
            end else if (b[7:6] == TAG_LUMA) begin
                held = b;
                pending = OP_LUMA;
            end else if (b[7:6] == TAG_INDEX) begin
                if (b >= palette_limit) begin
                    px = '0;
                    px.status = STATUS_ERROR;
                    px.column = col_count;
                    owed_pixels.push_back(px);
                    halted = 1;
                end else begin
                    if (alpha_mode)
                        alpha_lvl = palette[b[5:0]][23:16];
                    load_rgb(palette[b[5:0]][15:0]);
                    emit();
                end
            end else begin
                run_len = int'(b[5:0]) + 1;
                for (int i = 0; i < run_len && col_count < vis_end; i++)
                    emit();
            end
        endfunction

        function void take_item(logic [1:0] cmd, logic [7:0] b, logic [5:0] slot,
                                logic [23:0] word);
            case (cmd)
                CMD_PALETTE_WRITE: palette[slot] = word;
                CMD_ROW_START:     start_row();
                CMD_CODE:          decode_byte(b);
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_pixel(pixel_beat_t got);
            pixel_beat_t want;
            if (owed_pixels.size() == 0) begin
                $error("unexpected pixel beat: status %0d column %0d colour 0x%0h",
                       got.status, got.column, got.colour);
                mismatches++;
                return;
            end
            want = owed_pixels.pop_front();
            beats_checked++;
            if (want.status == STATUS_ERROR)
                error_beats++;
            compare_field("status", want.status, got.status);
            compare_field("column", want.column, got.column);
            compare_field("colour", want.colour, got.colour);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("row_last", want.row_last, got.row_last);
        endfunction
    endclass

    localparam logic [1:0] CMD_UNUSED  = 2'd3;     // reserved command, block ignores it
    localparam logic [7:0] RUN_FIRST   = 8'hC0;
    localparam logic [7:0] RUN_LAST    = 8'hFD;
    localparam int         SETTLE_CYC  = 100;      // settle margin for the longest run (62 pixels) plus RAM read
    localparam int         HOLD_CYC    = 400;      // long receiver hold-off for back pressure
    localparam longint     LIMIT_NS    = 64'd30_000_000;

    logic                     clk;
    logic                     rst_n        = 1'b0;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [CFG_AW-1:0]        paddr        = '0;
    logic [31:0]              pwdata       = '0;
    logic [31:0]              prdata;
    logic                     pready;
    logic                     cmd_valid    = 1'b0;
    logic                     cmd_stall;
    logic [1:0]               command      = CMD_CODE;
    logic [7:0]               code_byte    = '0;
    logic [5:0]               palette_slot = '0;
    logic [23:0]              palette_word = '0;
    logic                     pix_valid;
    logic                     pix_stall    = 1'b0;
    logic                     status;
    logic [15:0]              column;
    logic [15:0]              colour;
    logic [7:0]               alpha;
    logic                     row_last;

    row_pixel_model model = new();

    // Stimulus-side bookkeeping
    bit  pal_written [64];      // slots loaded so far; never index an unloaded one
    int  tx_idle_pct = 0;       // chance of a sender gap before each beat
    int  rx_idle_pct = 0;       // chance of a receiver stall burst per cycle
    int  hold_request = 0;      // main flow asks the receiver for a long hold-off
    int  hold_left = 0;
    int  stall_left = 0;
    int  items_sent = 0;
    int  settings_run = 0;

    qoi_rgb565_row_decoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .command      (command),
        .code_byte    (code_byte),
        .palette_slot (palette_slot),
        .palette_word (palette_word),
        .pix_valid    (pix_valid),
        .pix_stall    (pix_stall),
        .status       (status),
        .column       (column),
        .colour       (colour),
        .alpha        (alpha),
        .row_last     (row_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: far beyond the slowest legal run (every beat a 62-pixel run,
    // every pixel behind the longest receiver stall burst).
    initial
    begin
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Pixel side: check each accepted beat against the oldest owed pixel, then
    // pick the stall for the next cycle. Values read here are pre-edge values.
    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
            model.check_pixel({status, column, colour, alpha, row_last});
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pix_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            pix_stall <= 1'b1;
        end else if ($urandom_range(99, 0) < rx_idle_pct) begin
            stall_left = $urandom_range(14, 1) - 1;
            pix_stall <= 1'b1;
        end else begin
            pix_stall <= 1'b0;
        end
    end

    // APB write with setup and access phases; the model takes the value at the same edge.
    // The bus stays selected so the next write can follow directly.
    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        model.set_reg(idx, value);
    endtask

    task automatic apb_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(bit am, int pc, int vs, int ve);
        apb_write(REG_ALPHA_MODE, 32'(am));
        apb_write(REG_PALETTE_COUNT, pc);
        apb_write(REG_VISIBLE_START, vs);
        apb_write(REG_VISIBLE_END, ve);
        apb_idle();
        settings_run++;
    endtask

    // Offer one command beat, optionally after a sender gap, and wait for the
    // edge that takes it. Valid stays high on return so back-to-back beats
    // need no extra assignment.
    task automatic send_item(logic [1:0] cmd, logic [7:0] b, logic [5:0] slot,
                             logic [23:0] word);
        int gap;
        if ($urandom_range(99, 0) < tx_idle_pct) begin
            gap = $urandom_range(14, 1);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid    <= 1'b1;
        command      <= cmd;
        code_byte    <= b;
        palette_slot <= slot;
        palette_word <= word;
        do @(posedge clk); while (cmd_stall);
        model.take_item(cmd, b, slot, word);
        if (cmd == CMD_PALETTE_WRITE)
            pal_written[slot] = 1'b1;
        items_sent++;
    endtask

    task automatic send_code(logic [7:0] b);
        send_item(CMD_CODE, b, 6'($urandom), 24'($urandom));
    endtask

    // Wait until every owed pixel is out, then let a trailing run finish,
    // so the registers can be touched safely.
    task automatic drain();
        cmd_valid <= 1'b0;
        while (model.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Opening byte of a well-formed opcode with random content.
    function automatic logic [7:0] pick_opcode();
        logic [5:0] s6;
        case ($urandom_range(9, 0))
            0: return OPC_RAW_ALPHA;
            1: return OPC_RAW;
            2, 3: return {TAG_DIFF, 6'($urandom)};
            4: return {TAG_LUMA, 6'($urandom)};
            5, 6: begin
                if (model.palette_limit != 0 && $urandom_range(2, 0) != 0) begin
                    s6 = 6'($urandom_range(int'(model.palette_limit) - 1, 0));
                    if (pal_written[s6])
                        return {TAG_INDEX, s6};
                end
                // index past the palette: error beat, row halts
                if (model.palette_limit < 64)
                    return 8'($urandom_range(63, int'(model.palette_limit)));
                return {TAG_DIFF, 6'($urandom)};
            end
            7, 8: return 8'($urandom_range(int'(RUN_FIRST) + 7, RUN_FIRST));
            default: return 8'($urandom_range(RUN_LAST, RUN_FIRST));
        endcase
    endfunction

    task automatic random_item();
        logic [1:0]  cmd;
        logic [7:0]  b;
        logic [5:0]  slot;
        logic [23:0] word;
        int          pick;
        cmd  = CMD_CODE;
        b    = 8'($urandom);
        slot = 6'($urandom);
        word = 24'($urandom);
        pick = $urandom_range(99, 0);
        if (model.halted) begin
            // halted rows only come back through a row start
            if (pick < 40)
                cmd = CMD_ROW_START;
            else if (pick < 50)
                cmd = CMD_PALETTE_WRITE;
        end else if (pick < 4) begin
            cmd = CMD_ROW_START;
        end else if (pick < 11) begin
            cmd = CMD_PALETTE_WRITE;
            if (model.palette_limit != 0 && $urandom_range(1, 0) != 0)
                slot = 6'($urandom_range(int'(model.palette_limit) - 1, 0));
        end else if (pick < 14) begin
            cmd = CMD_UNUSED;
        end else if (pick >= 22 && model.pending == OP_NONE) begin
            b = pick_opcode();
        end
        // noise must not land on a palette slot that was never loaded
        if (model.reads_palette(cmd, b) && !pal_written[b[5:0]])
            b = {TAG_DIFF, b[5:0]};
        send_item(cmd, b, slot, word);
    endtask

    task automatic random_phase(bit am, int pc, int vs, int ve, int n_items,
                                int tx_pct, int rx_pct);
        set_window(am, pc, vs, ve);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (n_items) random_item();
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: alpha mode, window columns 2..39, 16 palette entries.
        set_window(1'b1, 16, 2, 40);
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        send_item(CMD_PALETTE_WRITE, 8'h00, 6'd0, 24'h000000);
        send_item(CMD_PALETTE_WRITE, 8'hFF, 6'd63, 24'hFFFFFF);
        send_item(CMD_PALETTE_WRITE, 8'h00, 6'd5, 24'h5AA55A);
        send_code(8'h00);                   // before any row start: ignored
        send_item(CMD_ROW_START, 8'h00, 6'd0, 24'h0);
        send_code(OPC_RAW_ALPHA);           // column 0, left of window
        send_code(8'h80);
        send_code(8'hF8);
        send_code(8'h1F);
        send_code(OPC_RAW);                 // column 1, alpha kept
        send_code(8'h07);
        send_code(8'hE0);
        send_code(8'h40);                   // smallest diff, first visible column
        send_code(8'h7F);                   // largest diff
        send_code(8'h80);                   // luma extremes
        send_code(8'h00);
        send_code(8'hBF);
        send_code(8'hFF);
        send_code(8'h00);                   // palette index 0
        send_code(8'h05);
        send_code(RUN_FIRST);               // run of one
        send_code(RUN_LAST);                // run of 62, cut at the window end
        send_code(8'h41);                   // row finished: ignored
        send_item(CMD_UNUSED, 8'hA5, 6'h2A, 24'h123456);
        send_item(CMD_ROW_START, 8'h00, 6'd0, 24'h0);
        send_code(8'h10);                   // index past palette_count: error
        send_code(8'h3F);                   // halted row: ignored
        drain();

        // Back pressure: receiver holds off while the sender keeps offering.
        hold_request = HOLD_CYC;
        random_phase(1'b0, 64, 0, 300, 50, 10, 20);
        random_phase(1'b1, 37, 10, 20, 40, 30, 30);
        random_phase(1'b0, 0, 0, 65535, 30, 15, 15);
        random_phase(1'b1, 5, 65535, 65535, 25, 20, 10);
        random_phase(1'b0, 1, 0, 0, 15, 10, 10);
        random_phase(1'b1, 64, 1, 120, 45, 15, 40);
        // closing stretch runs at full rate on both sides
        random_phase(1'b0, 23, 4, 90, 55, 0, 0);

        $display("tb: %0d command beats over %0d register settings", items_sent,
                 settings_run);
        $display("tb: %0d pixel beats checked, %0d of them palette errors",
                 model.beats_checked, model.error_beats);
        if (model.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
